// ----- rtl/core/ascii85_decoder_core_assert.svh -----
// assertion macros for the ascii85 decoder checker
// no dependencies; included by files that carry assertions
`ifndef ASCII85_DECODER_CORE_ASSERT_SVH
`define ASCII85_DECODER_CORE_ASSERT_SVH

// property checked at every edge, reset included
`define A85D_ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("a85d assertion failed");

// property checked only while out of reset
`define A85D_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("a85d assertion failed");

`endif

// ----- rtl/core/a85d_pkg.sv -----
// shared types, constants and power table for the ascii85 decoder
// no dependencies
`default_nettype none

package a85d_pkg;

  localparam int unsigned QDepth  = 4;
  localparam int unsigned QAddrW  = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [7:0]  FirstDigit   = 8'd33;
  localparam logic [7:0]  LastDigit    = 8'd117;
  localparam logic [7:0]  ZeroGroupChr = 8'd122;
  localparam logic [31:0] DigitBase    = 32'd85;
  localparam logic [2:0]  GroupDigits  = 3'd5;
  localparam logic [2:0]  LastSlot     = 3'd4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } out_item_t;

  // one group request from front to back
  typedef struct packed {
    logic [31:0] word;      // accumulator before padding
    logic [2:0]  pad_k;     // pad digits still to fold in (0..3)
    logic [1:0]  len_m1;    // bytes to emit minus one
    logic        fin;       // last byte carries final_byte
  } op_t;

  // 85^k, k = 0..4
  function automatic logic [31:0] pad_pow(input logic [2:0] k);
    logic [31:0] p;
    unique case (k)
      3'd0:    p = 32'd1;
      3'd1:    p = 32'd85;
      3'd2:    p = 32'd7225;
      3'd3:    p = 32'd614125;
      3'd4:    p = 32'd52200625;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ascii85_decoder_core.sv -----
// ascii85 decoder top level: front, request queue and back
// depends on a85d_pkg, a85d_front, a85d_fifo, a85d_back
//
// Input channel: one text character per request with its end-of-text flag,
// taken on a clock edge with in_push high and in_full low. Digits '!'..'u'
// fold into the group accumulator; 'z' at a group boundary gives four zero
// bytes; any other character is dropped but its end flag still closes the text.
// Result channel: decoded bytes, most significant of each group first, shown
// while out_empty is low and taken with out_pop. final_byte marks the last byte
// caused by an end-flagged character.
// Throughput: one character per cycle while in_full is low and one byte per cycle
// while the receiver pops. Five digits give four bytes, so plain text streams at
// full rate; runs of 'z', four bytes each, are limited by the byte port.
// The first byte of a group becomes visible after the closing character passes
// the queue write, the pad multiply-add register and the byte register.
// A four-entry request queue sits between the character side and the byte side;
// when the receiver stalls, the queue fills and in_full rises.
// Reset (rst_n low, synchronous) empties the queue and clears the group.
`default_nettype none

module ascii85_decoder_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire a85d_pkg::in_item_t in_item,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output a85d_pkg::out_item_t     out_item
);

  logic          q_push, q_full, q_pop, q_valid;
  a85d_pkg::op_t q_wop, q_rop;

  assign in_full = q_full;

  a85d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_op    (q_wop)
  );

  a85d_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_wop),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (q_rop),
    .valid   (q_valid)
  );

  a85d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_rop),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- rtl/core/a85d_fifo.sv -----
// short request queue between the decoder front and back
// depends on a85d_pkg
`default_nettype none

module a85d_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire a85d_pkg::op_t  push_op,
  output logic                full,
  input  wire logic           pop,
  output a85d_pkg::op_t       pop_op,
  output logic                valid
);

  a85d_pkg::op_t                    mem [a85d_pkg::QDepth];
  logic [a85d_pkg::QAddrW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [a85d_pkg::QAddrW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [a85d_pkg::QCntW-1:0]       cnt_r, cnt_nxt;
  logic                             do_push, do_pop;

  assign full    = (cnt_r == a85d_pkg::QCntW'(a85d_pkg::QDepth));
  assign valid   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_op  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/a85d_front.sv -----
// decoder front: classifies characters, folds digits into the group accumulator
// and queues one group request per character that yields bytes; depends on a85d_pkg
`default_nettype none

module a85d_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire a85d_pkg::in_item_t in_item,
  input  wire logic              q_full,
  output logic                   q_push,
  output a85d_pkg::op_t          q_op
);

  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        accept;
  logic        is_digit, is_zero;
  logic [6:0]  digit;
  logic [31:0] acc_mac;
  logic [2:0]  cnt_inc;

  assign accept   = in_push && !q_full;
  assign is_digit = (in_item.char_code >= a85d_pkg::FirstDigit) &&
                    (in_item.char_code <= a85d_pkg::LastDigit);
  assign is_zero  = (in_item.char_code == a85d_pkg::ZeroGroupChr) && (cnt_r == '0);
  assign digit    = in_item.char_code[6:0] - a85d_pkg::FirstDigit[6:0];
  assign acc_mac  = acc_r * a85d_pkg::DigitBase + {25'd0, digit};
  assign cnt_inc  = cnt_r + 3'd1;

  always_comb begin
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    q_push      = 1'b0;
    q_op.word   = acc_mac;
    q_op.pad_k  = '0;
    q_op.len_m1 = 2'd3;
    q_op.fin    = in_item.end_of_text;
    if (is_digit) begin
      if (cnt_r == a85d_pkg::LastSlot) begin
        q_push  = 1'b1;
        acc_nxt = '0;
        cnt_nxt = '0;
      end else begin
        acc_nxt = acc_mac;
        cnt_nxt = cnt_inc;
        // partial group closed by the end flag: n digits give n-1 bytes
        if (in_item.end_of_text && cnt_inc >= 3'd2) begin
          q_push      = 1'b1;
          q_op.pad_k  = a85d_pkg::GroupDigits - cnt_inc;
          q_op.len_m1 = 2'(cnt_inc - 3'd2);
        end
      end
    end else if (is_zero) begin
      q_push    = 1'b1;
      q_op.word = '0;
    end else if (in_item.end_of_text && cnt_r >= 3'd2) begin
      q_push      = 1'b1;
      q_op.word   = acc_r;
      q_op.pad_k  = a85d_pkg::GroupDigits - cnt_r;
      q_op.len_m1 = 2'(cnt_r - 3'd2);
    end
    if (in_item.end_of_text) begin
      acc_nxt = '0;
      cnt_nxt = '0;
    end
    if (!accept) begin
      q_push  = 1'b0;
      acc_nxt = acc_r;
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/a85d_back.sv -----
// decoder back: pads partial groups with one multiply-add stage, then sends
// the group out one byte per cycle while the receiver pops, most significant first; depends on a85d_pkg
`default_nettype none

module a85d_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire a85d_pkg::op_t q_op,
  output logic               q_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output a85d_pkg::out_item_t out_item
);

  // pad stage
  logic        pv_r, pv_nxt;
  logic [31:0] pword_r;
  logic [1:0]  plen_r;
  logic        pfin_r;
  // byte serializer
  logic        sv_r, sv_nxt;
  logic [31:0] sword_r, sword_nxt;
  logic [1:0]  slen_r, slen_nxt;
  logic        sfin_r, sfin_nxt;

  logic        pop_fire, ser_ld, pad_ld;
  logic [31:0] pow_k, padded;

  assign pop_fire = out_pop && sv_r;
  assign ser_ld   = pv_r && (!sv_r || (pop_fire && slen_r == '0));
  assign pad_ld   = q_valid && (!pv_r || ser_ld);
  assign q_pop    = pad_ld;

  // padding with digit 84 for k places: (w+1)*85^k - 1 = w*85^k + (85^k - 1)
  assign pow_k  = a85d_pkg::pad_pow(q_op.pad_k);
  assign padded = q_op.word * pow_k + (pow_k - 32'd1);

  always_comb begin
    pv_nxt    = pv_r;
    sv_nxt    = sv_r;
    sword_nxt = sword_r;
    slen_nxt  = slen_r;
    sfin_nxt  = sfin_r;
    if (pad_ld) begin
      pv_nxt = 1'b1;
    end else if (ser_ld) begin
      pv_nxt = 1'b0;
    end
    if (ser_ld) begin
      sv_nxt    = 1'b1;
      sword_nxt = pword_r;
      slen_nxt  = plen_r;
      sfin_nxt  = pfin_r;
    end else if (pop_fire) begin
      if (slen_r == '0) begin
        sv_nxt = 1'b0;
      end else begin
        sword_nxt = {sword_r[23:0], 8'd0};
        slen_nxt  = slen_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      pv_r <= pv_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pad_ld) begin
      pword_r <= padded;
      plen_r  <= q_op.len_m1;
      pfin_r  <= q_op.fin;
    end
    sword_r <= sword_nxt;
    slen_r  <= slen_nxt;
    sfin_r  <= sfin_nxt;
  end

  assign out_empty           = !sv_r;
  assign out_item.data_byte  = sword_r[31:24];
  assign out_item.final_byte = sfin_r && (slen_r == '0);

endmodule

`default_nettype wire

// ----- rtl/core/a85d_checker.sv -----
// port-level checks for the ascii85 decoder, bound to the top level
// depends on a85d_pkg and ascii85_decoder_core_assert.svh
`default_nettype none
`include "ascii85_decoder_core_assert.svh"

module a85d_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_full,
  input wire logic                out_empty,
  input wire logic                out_pop,
  input wire a85d_pkg::out_item_t out_item
);

  // a waiting byte holds until taken
  `A85D_ASSERT_RST(a_out_hold, clk, rst_n, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
  // reset leaves the output empty and the input not full
  `A85D_ASSERT_CLK(a_rst_clear, clk, !rst_n |=> (out_empty && !in_full))
  // the input side only backs up behind a stalled byte
  `A85D_ASSERT_RST(a_full_pending, clk, rst_n, in_full |-> !out_empty)

endmodule

bind ascii85_decoder_core a85d_checker u_a85d_checker (.*);

`default_nettype wire

// ----- bench/ascii85_decoder_core_tb.sv -----
// self-checking testbench for the ascii85 decoder core: directed and random text,
// bursty input, receiver stalls and byte-by-byte comparison against a behavioral predictor
// depends on a85d_pkg and ascii85_decoder_core
module ascii85_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] PadDigit = 32'd84;
  localparam int unsigned StallLimit = 1000;

  // receiver behavior
  localparam logic [1:0] POP_FREE   = 2'd0;
  localparam logic [1:0] POP_RANDOM = 2'd1;
  localparam logic [1:0] POP_SLOW   = 2'd2;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  a85d_pkg::in_item_t  in_item = '0;
  logic                in_full;
  logic                out_empty;
  logic                out_pop = 1'b0;
  a85d_pkg::out_item_t out_item;

  // predictor state
  logic [31:0]         group_acc = '0;
  logic [2:0]          digits_held = '0;
  a85d_pkg::out_item_t expected_bytes[$];

  logic [1:0]          pop_mode = POP_FREE;
  logic [4:0]          stall_phase = '0;
  bit                  gaps_on = 1'b0;
  int unsigned         burst_left = 0;
  int unsigned         idle_cycles = 0;
  int unsigned         chars_sent = 0;
  int unsigned         texts_closed = 0;
  int unsigned         bytes_checked = 0;
  int unsigned         full_cycles = 0;
  int unsigned         mismatches = 0;
  a85d_pkg::out_item_t want_byte;

  ascii85_decoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // bytes one character causes, in order, with the final marker on the last
  task automatic predict_char(input a85d_pkg::in_item_t item);
    logic [7:0]          grp_bytes [0:7];
    logic [31:0]         padded;
    int unsigned         n;
    int unsigned         k;
    a85d_pkg::out_item_t exp_byte;
    n = 0;
    if (item.char_code >= a85d_pkg::FirstDigit && item.char_code <= a85d_pkg::LastDigit) begin
      group_acc = group_acc * a85d_pkg::DigitBase +
                  {24'd0, item.char_code - a85d_pkg::FirstDigit};
      digits_held = digits_held + 3'd1;
      if (digits_held == a85d_pkg::GroupDigits) begin
        for (k = 0; k < 4; k++) grp_bytes[k] = 8'(group_acc >> (24 - 8 * k));
        n = 4;
        group_acc = '0;
        digits_held = '0;
      end
    end else if (item.char_code == a85d_pkg::ZeroGroupChr && digits_held == 3'd0) begin
      for (k = 0; k < 4; k++) grp_bytes[k] = 8'h00;
      n = 4;
    end
    if (item.end_of_text) begin
      if (digits_held != 3'd0) begin
        padded = group_acc;
        for (k = digits_held; k < a85d_pkg::GroupDigits; k++)
          padded = padded * a85d_pkg::DigitBase + PadDigit;
        // a single pending digit yields nothing
        for (k = 0; k + 1 < digits_held; k++) grp_bytes[n + k] = 8'(padded >> (24 - 8 * k));
        n = n + digits_held - 1;
      end
      group_acc = '0;
      digits_held = '0;
      texts_closed++;
    end
    for (k = 0; k < n; k++) begin
      exp_byte.data_byte = grp_bytes[k];
      exp_byte.final_byte = item.end_of_text && (k == n - 1);
      expected_bytes = {expected_bytes, exp_byte};
    end
  endtask

  // one character request; push stays high across a burst
  task automatic send_char(input logic [7:0] code, input logic eot);
    a85d_pkg::in_item_t item;
    if (gaps_on && burst_left == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    item.char_code = code;
    item.end_of_text = eot;
    in_item <= item;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    predict_char(item);
    if (burst_left > 0) burst_left--;
    chars_sent++;
  endtask

  function automatic logic [7:0] rand_digit();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return a85d_pkg::FirstDigit;
    if (sel == 1) return a85d_pkg::LastDigit;
    return a85d_pkg::FirstDigit + 8'($urandom_range(0, 84));
  endfunction

  // mostly well-formed groups, with zero groups, closed texts and noise mixed in
  task automatic send_random_text(input int unsigned target);
    int unsigned made;
    int unsigned pick;
    int unsigned len;
    int unsigned k;
    bit          on_noise;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        for (k = 0; k < 5; k++) send_char(rand_digit(), 1'b0);
        made += 5;
      end else if (pick < 68) begin
        send_char(a85d_pkg::ZeroGroupChr, $urandom_range(0, 9) == 0);
        made++;
      end else if (pick < 85) begin
        len = $urandom_range(0, 5);
        on_noise = (len == 0) || ($urandom_range(0, 3) == 0);
        for (k = 0; k < len; k++) send_char(rand_digit(), !on_noise && (k == len - 1));
        if (on_noise) send_char(8'($urandom_range(0, 255)), 1'b1);
        made += len + 1;
      end else begin
        send_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        made++;
      end
    end
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    pop_mode = POP_FREE;
    gaps_on = 1'b0;
    // lowest group, closed by the text end on its fifth digit
    repeat (4) send_char("!", 1'b0);
    send_char("!", 1'b1);
    // highest group wraps past 2^32
    repeat (5) send_char("u", 1'b0);
    send_char(a85d_pkg::ZeroGroupChr, 1'b0);
    // 'z' inside a group and other characters are skipped
    send_char("s", 1'b0);
    send_char(a85d_pkg::ZeroGroupChr, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("v", 1'b0);
    send_char(8'h00, 1'b0);
    send_char("8", 1'b1);
    // single pending digit at the end is dropped
    send_char("@", 1'b1);
    send_char(a85d_pkg::ZeroGroupChr, 1'b1);
    // end flag on a skipped character still closes the text
    send_char("A", 1'b0);
    send_char("B", 1'b0);
    send_char("C", 1'b0);
    send_char(8'h20, 1'b1);
    // padding wraps as well
    repeat (3) send_char("u", 1'b0);
    send_char("u", 1'b1);
  endtask

  task automatic test_full_rate_stream();
    pop_mode = POP_FREE;
    gaps_on = 1'b0;
    send_random_text(120);
  endtask

  task automatic test_bursty_traffic();
    pop_mode = POP_RANDOM;
    gaps_on = 1'b1;
    burst_left = 0;
    send_random_text(200);
  endtask

  task automatic test_back_pressure();
    pop_mode = POP_SLOW;
    gaps_on = 1'b0;
    send_random_text(115);
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    stall_phase <= stall_phase + 5'd1;
    case (pop_mode)
      POP_FREE: begin
        out_pop <= 1'b1;
      end
      POP_RANDOM: begin
        out_pop <= stall_phase[4] || ($urandom_range(0, 2) != 0);
      end
      default: begin
        out_pop <= (stall_phase[2:0] == 3'd7) || ($urandom_range(0, 15) == 0);
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %h final %b",
                                  out_item.data_byte, out_item.final_byte));
      end else begin
        want_byte = expected_bytes.pop_front();
        if (out_item.data_byte !== want_byte.data_byte)
          report_mismatch($sformatf("byte %0d data_byte expected %h got %h",
                                    bytes_checked, want_byte.data_byte, out_item.data_byte));
        if (out_item.final_byte !== want_byte.final_byte)
          report_mismatch($sformatf("byte %0d final_byte expected %b got %b",
                                    bytes_checked, want_byte.final_byte, out_item.final_byte));
      end
      bytes_checked++;
    end
  end

  // watchdog on cycles with no request taken on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && in_full) full_cycles++;
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("[%0t] no progress for %0d cycles", $time, StallLimit);
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_full_rate_stream();
    test_bursty_traffic();
    test_back_pressure();
    drain_results();
    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
    $display("covered %0d characters in %0d closed texts, %0d decoded bytes compared",
             chars_sent, texts_closed, bytes_checked);
    $display("input held off by a full queue on %0d cycles, %0d mismatches",
             full_cycles, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/a85d_pkg.sv
rtl/core/a85d_fifo.sv
rtl/core/a85d_front.sv
rtl/core/a85d_back.sv
rtl/core/ascii85_decoder_core.sv
rtl/core/a85d_checker.sv
bench/ascii85_decoder_core_tb.sv
